@@ rtl/utf8v_pkg.sv @@
// shared types and constants of the utf8 input validator
package utf8v_pkg;

    // field widths
    localparam int DATA_W      = 8;
    localparam int MAX_LEN_W   = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CP_W        = 21;

    // register reset values
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'd1000;
    localparam logic REJECT_NUL_RESET = 1'b1;

    // code point bounds
    localparam logic [CP_W-1:0] CP_MIN_SEQ1  = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_SEQ2  = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_SEQ3  = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_LENGTH = 2'd0,
        CFG_REJECT_NUL = 2'd1
    } t_cfg_index;

    // verdict codes
    typedef enum logic [1:0] {
        VERDICT_ACCEPTED  = 2'd0,
        VERDICT_NUL       = 2'd1,
        VERDICT_TOO_LONG  = 2'd2,
        VERDICT_BAD_UTF8  = 2'd3
    } t_verdict;

    // utf8 decoder state carried between bytes
    typedef struct packed {
        logic [1:0]      pending;
        logic [1:0]      seq_len;
        logic [CP_W-1:0] cp;
        logic            err;
    } t_dec_state;

endpackage

@@ rtl/utf8v_input_reg.sv @@
// input register stage that holds one byte item until the core takes it
module utf8v_input_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [utf8v_pkg::DATA_W-1:0] i_data_byte,
    input  logic                         i_last_byte,
    input  logic                         i_take,
    output logic                         o_valid,
    output logic [utf8v_pkg::DATA_W-1:0] o_data_byte,
    output logic                         o_last_byte
);
    import utf8v_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_byte;
    logic              r_last;

    // free when empty or when the held item moves on this cycle
    assign o_in_ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_byte;
    assign o_last_byte = r_last;

endmodule

@@ rtl/utf8v_decoder.sv @@
// next state of the utf8 sequence check for one byte
module utf8v_decoder (
    input  utf8v_pkg::t_dec_state         i_cur,
    input  logic [utf8v_pkg::DATA_W-1:0]  i_byte,
    output utf8v_pkg::t_dec_state         o_next
);
    import utf8v_pkg::*;

    logic [CP_W-1:0] cp_shift;
    logic            cp_bad;

    // code point with this continuation appended
    assign cp_shift = {i_cur.cp[CP_W-7:0], i_byte[5:0]};

    // overlong, out of range or surrogate when the sequence completes
    assign cp_bad = (i_cur.seq_len == 2'd1 && cp_shift < CP_MIN_SEQ1) ||
                    (i_cur.seq_len == 2'd2 && cp_shift < CP_MIN_SEQ2) ||
                    (i_cur.seq_len == 2'd3 && cp_shift < CP_MIN_SEQ3) ||
                    (cp_shift > CP_MAX) ||
                    (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI);

    always_comb begin
        o_next = i_cur;
        priority if (i_cur.err) begin
            // a fault sticks for the rest of the string
        end else if (i_cur.pending != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                o_next.err = 1'b1;
            end else begin
                o_next.cp      = cp_shift;
                o_next.pending = i_cur.pending - 2'd1;
                if (i_cur.pending == 2'd1) begin
                    o_next.err     = cp_bad;
                    o_next.seq_len = 2'd0;
                    o_next.cp      = '0;
                end
            end
        end else if (!i_byte[7]) begin
            // plain ascii
        end else if (i_byte[7:5] == 3'b110) begin
            if (i_byte[4:0] == 5'd0) begin
                o_next.err = 1'b1;
            end else begin
                o_next.seq_len = 2'd1;
                o_next.pending = 2'd1;
                o_next.cp      = {{(CP_W-5){1'b0}}, i_byte[4:0]};
            end
        end else if (i_byte[7:4] == 4'b1110) begin
            o_next.seq_len = 2'd2;
            o_next.pending = 2'd2;
            o_next.cp      = {{(CP_W-4){1'b0}}, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            if (i_byte[2:0] > 3'd4) begin
                o_next.err = 1'b1;
            end else begin
                o_next.seq_len = 2'd3;
                o_next.pending = 2'd3;
                o_next.cp      = {{(CP_W-3){1'b0}}, i_byte[2:0]};
            end
        end else begin
            // stray continuation or lead byte f8 and above
            o_next.err = 1'b1;
        end
    end

endmodule

@@ rtl/utf8v_core.sv @@
// per-string state, length count, verdict and result register
module utf8v_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [utf8v_pkg::DATA_W-1:0]    i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_take,
    input  logic [utf8v_pkg::MAX_LEN_W-1:0] i_max_length,
    input  logic                            i_reject_nul,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_verdict,
    output logic [COUNT_BITS:0]             o_byte_total
);
    import utf8v_pkg::*;

    localparam int CNT_W = COUNT_BITS + 1;
    localparam int CMP_W = (CNT_W > MAX_LEN_W) ? CNT_W : MAX_LEN_W;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};

    t_dec_state       r_dec;
    t_dec_state       dec_next;
    logic             r_nul;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             n_nul;
    logic             out_free;
    logic             bad_utf8;
    logic             too_long;
    t_verdict         n_verdict;
    logic             r_out_valid;
    t_verdict         r_verdict;
    logic [CNT_W-1:0] r_total;

    utf8v_decoder u_decoder (
        .i_cur  (r_dec),
        .i_byte (i_data_byte),
        .o_next (dec_next)
    );

    // a final byte waits only for room in the result register
    assign out_free = !r_out_valid || i_out_ready;
    assign o_take   = i_valid && (!i_last_byte || out_free);

    // saturating length and nul tracking
    assign n_count = (r_count == COUNT_LIMIT) ? r_count : r_count + CNT_W'(1);
    assign n_nul   = r_nul || (i_data_byte == '0);

    // verdict in priority order
    assign bad_utf8 = dec_next.err || (dec_next.pending != 2'd0);
    assign too_long = CMP_W'(n_count) > CMP_W'(i_max_length);

    always_comb begin
        priority if (n_nul && i_reject_nul) begin
            n_verdict = VERDICT_NUL;
        end else if (too_long) begin
            n_verdict = VERDICT_TOO_LONG;
        end else if (bad_utf8) begin
            n_verdict = VERDICT_BAD_UTF8;
        end else begin
            n_verdict = VERDICT_ACCEPTED;
        end
    end

    // string state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec   <= '0;
            r_nul   <= 1'b0;
            r_count <= '0;
        end else if (o_take) begin
            if (i_last_byte) begin
                r_dec   <= '0;
                r_nul   <= 1'b0;
                r_count <= '0;
            end else begin
                r_dec   <= dec_next;
                r_nul   <= n_nul;
                r_count <= n_count;
            end
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_last_byte) begin
            r_verdict <= n_verdict;
            r_total   <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_verdict    = r_verdict;
    assign o_byte_total = r_total;

endmodule

@@ rtl/utf8_input_validator.sv @@
// top level of the utf8 input validator
// Takes one string byte per item, the final byte flagged by i_last_byte, and gives
// one result item per string: the verdict (nul byte, then too long, then invalid
// utf-8, else accepted) and the byte count, saturating at 2**COUNT_BITS. One byte
// is taken every cycle unless a final byte is held back; a byte passes the input
// register and then the state update in the core, and the result of a string is
// registered when the core takes its final byte. A final byte waits in the input
// register only while the result register holds an earlier result not yet taken.
// Configuration writes take effect at once and are meant to happen between strings.
module utf8_input_validator #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [utf8v_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [utf8v_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [utf8v_pkg::DATA_W-1:0]      i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_verdict,
    output logic [COUNT_BITS:0]               o_byte_total
);
    import utf8v_pkg::*;

    logic [MAX_LEN_W-1:0] r_max_length;
    logic                 r_reject_nul;
    logic                 stg_valid;
    logic [DATA_W-1:0]    stg_byte;
    logic                 stg_last;
    logic                 take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LEN_RESET;
            r_reject_nul <= REJECT_NUL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_LENGTH: r_max_length <= i_cfg_data[MAX_LEN_W-1:0];
                CFG_REJECT_NUL: r_reject_nul <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    utf8v_input_reg u_input_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_take      (take),
        .o_valid     (stg_valid),
        .o_data_byte (stg_byte),
        .o_last_byte (stg_last)
    );

    utf8v_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (stg_valid),
        .i_data_byte  (stg_byte),
        .i_last_byte  (stg_last),
        .o_take       (take),
        .i_max_length (r_max_length),
        .i_reject_nul (r_reject_nul),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict),
        .o_byte_total (o_byte_total)
    );

    // a final byte is never taken while a result is stuck in the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !(take && stg_last))
        else $error("final byte taken over a pending result");

    // a final byte always produces a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && stg_last) |=> o_out_valid)
        else $error("result missing after final byte");

    // the byte count of a result is never zero
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_total != '0))
        else $error("result with zero byte count");

    // the input register only drains into the core
    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> stg_valid)
        else $error("core took from an empty input register");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench of the utf8 input validator: directed and random strings
`timescale 1ns / 1ps

import utf8v_pkg::*;

// predicts the verdict of every string and checks the results of the block
class verdict_scoreboard;

    typedef struct {
        t_verdict    verdict;
        logic [16:0] total;
    } t_verdict_item;

    // register copies
    logic [15:0] length_limit;
    logic        nul_reject;

    // per-string decoder state
    logic [1:0]  conts_left;
    logic [1:0]  cont_total;
    logic [20:0] cp_accum;
    bit          utf8_fault;
    bit          zero_seen;
    logic [16:0] byte_count;

    t_verdict_item pending_verdicts[$];
    int mismatches;
    int checked;
    int verdict_counts[4];

    function new();
        length_limit = 16'd1000;
        nul_reject   = 1'b1;
        clear_string();
    endfunction

    function void clear_string();
        conts_left = '0;
        cont_total = '0;
        cp_accum   = '0;
        utf8_fault = 1'b0;
        zero_seen  = 1'b0;
        byte_count = '0;
    endfunction

    function void set_register(t_cfg_index idx, logic [15:0] value);
        case (idx)
            CFG_MAX_LENGTH: length_limit = value;
            CFG_REJECT_NUL: nul_reject = value[0];
            default: ;
        endcase
    endfunction

    // utf-8 decoding of one byte; a fault sticks until the end of the string
    function void decode_byte(logic [7:0] b);
        if (utf8_fault) return;
        if (conts_left != 0) begin
            if (b[7:6] != 2'b10) begin
                utf8_fault = 1'b1;
                return;
            end
            cp_accum = {cp_accum[14:0], b[5:0]};
            conts_left--;
            if (conts_left == 0) begin
                if ((cont_total == 1 && cp_accum < 21'h80) ||
                    (cont_total == 2 && cp_accum < 21'h800) ||
                    (cont_total == 3 && cp_accum < 21'h10000) ||
                    cp_accum > 21'h10FFFF ||
                    (cp_accum >= 21'hD800 && cp_accum <= 21'hDFFF))
                    utf8_fault = 1'b1;
                cont_total = '0;
                cp_accum   = '0;
            end
            return;
        end
        if (!b[7]) return;
        if (b[7:5] == 3'b110) begin
            if (b[4:0] == 5'd0) begin
                utf8_fault = 1'b1;
                return;
            end
            cont_total = 2'd1;
            cp_accum   = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            cont_total = 2'd2;
            cp_accum   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            if (b[2:0] > 3'd4) begin
                utf8_fault = 1'b1;
                return;
            end
            cont_total = 2'd3;
            cp_accum   = {18'd0, b[2:0]};
        end else begin
            utf8_fault = 1'b1;
            return;
        end
        conts_left = cont_total;
    endfunction

    // called for every accepted input item
    function void note_byte(logic [7:0] b, logic last);
        t_verdict_item want;
        if (b == 8'h00) zero_seen = 1'b1;
        if (!byte_count[16]) byte_count++;
        decode_byte(b);
        if (!last) return;
        // sequence cut off by the end of the string
        if (conts_left != 0) utf8_fault = 1'b1;
        if (zero_seen && nul_reject)
            want.verdict = VERDICT_NUL;
        else if (byte_count > {1'b0, length_limit})
            want.verdict = VERDICT_TOO_LONG;
        else if (utf8_fault)
            want.verdict = VERDICT_BAD_UTF8;
        else
            want.verdict = VERDICT_ACCEPTED;
        want.total = byte_count;
        pending_verdicts = {pending_verdicts, want};
        clear_string();
    endfunction

    // called for every accepted result item
    function void check_result(logic [1:0] verdict, logic [16:0] total);
        t_verdict_item want;
        checked++;
        if (!$isunknown(verdict)) verdict_counts[verdict]++;
        if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result item: verdict %0d byte_total %0d",
                         $realtime, verdict, total);
            return;
        end
        want = pending_verdicts.pop_front();
        if (verdict !== want.verdict || total !== want.total) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch: verdict exp %0d got %0d, byte_total exp %0d got %0d",
                         $realtime, want.verdict, verdict, want.total, total);
        end
    endfunction

    function int outstanding();
        return pending_verdicts.size();
    endfunction

endclass

module testbench;

    typedef logic [7:0] t_byte_q[$];

    typedef enum {
        FAULT_RANDOM_BYTE,
        FAULT_OVERLONG,
        FAULT_SURROGATE,
        FAULT_ABOVE_MAX,
        FAULT_TRUNCATED,
        FAULT_NO_CONT
    } t_fault_kind;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 60;
    localparam int PHASES         = 5;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [DATA_W-1:0]      i_data_byte;
    logic                   i_last_byte;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [1:0]             o_verdict;
    logic [16:0]            o_byte_total;

    verdict_scoreboard sb;
    bit no_gaps;
    bit hold_request;
    int quiet_cycles;
    int strings_sent;
    int bytes_sent;
    int reg_writes;

    utf8_input_validator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict),
        .o_byte_total (o_byte_total)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("utf8_input_validator test failed");
            $finish;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // utf-8 encoding of a code point in a forced number of bytes
    function automatic t_byte_q encode_point(logic [20:0] cp, int nbytes);
        t_byte_q s;
        case (nbytes)
            1: s = '{{1'b0, cp[6:0]}};
            2: s = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
            3: s = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
            default: s = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                           {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
        endcase
        return s;
    endfunction

    // legal code point that needs exactly nbytes
    function automatic logic [20:0] valid_point(int nbytes);
        logic [20:0] cp;
        case (nbytes)
            2: cp = 21'($urandom_range(21'h80, 21'h7FF));
            3: begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        return cp;
    endfunction

    // one character, mostly well formed, sometimes broken
    function automatic t_byte_q random_char();
        t_byte_q c;
        int pick;
        int nb;
        int pos;
        t_fault_kind fault;
        pick = $urandom_range(0, 99);
        nb = $urandom_range(2, 4);
        if (pick < 40) begin
            c = encode_point(21'($urandom_range(1, 8'h7F)), 1);
        end else if (pick < 44) begin
            c = '{8'h00};
        end else if (pick < 85) begin
            c = encode_point(valid_point(nb), nb);
        end else begin
            fault = t_fault_kind'($urandom_range(0, 5));
            case (fault)
                FAULT_RANDOM_BYTE: begin
                    c = '{8'h00};
                    c[0] = 8'($urandom_range(0, 255));
                end
                FAULT_OVERLONG: begin
                    c = encode_point(21'($urandom_range(0, nb == 2 ? 'h7F :
                                                            nb == 3 ? 'h7FF : 'hFFFF)),
                                     nb);
                end
                FAULT_SURROGATE: begin
                    c = encode_point(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
                end
                FAULT_ABOVE_MAX: begin
                    c = encode_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
                end
                FAULT_TRUNCATED: begin
                    c = encode_point(valid_point(nb), nb);
                    void'(c.pop_back());
                end
                default: begin
                    // a continuation replaced by a byte not of the form 10xxxxxx
                    c = encode_point(valid_point(nb), nb);
                    pos = $urandom_range(1, nb - 1);
                    pick = $urandom_range(0, 191);
                    c[pos] = (pick < 128) ? 8'(pick) : 8'(pick + 64);
                end
            endcase
        end
        return c;
    endfunction

    function automatic t_byte_q random_string();
        t_byte_q s;
        int chars;
        chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        repeat (chars) s = {s, random_char()};
        return s;
    endfunction

    // offer one input item and wait for its handshake
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_string(input t_byte_q s);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
        strings_sent++;
    endtask

    // one long string of repeated or random bytes, no gaps
    task automatic send_long_string(input int len, input bit random_bytes);
        no_gaps = 1'b1;
        for (int i = 0; i < len; i++)
            send_byte(random_bytes ? 8'($urandom_range(0, 255)) : 8'h41, i == len - 1);
        strings_sent++;
    endtask

    // stop offering and wait until every verdict is back and the pipeline is empty
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, value);
        reg_writes++;
    endtask

    task automatic set_limits(input logic [15:0] max_len, input logic nul_bit);
        write_register(CFG_MAX_LENGTH, max_len);
        write_register(CFG_REJECT_NUL, {15'd0, nul_bit});
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (i_rst_n) sb.check_result(o_verdict, o_byte_total);
        end
    end

    // stimulus
    initial begin
        logic [15:0] phase_max[PHASES];
        logic        phase_nul[PHASES];
        int          phase_bytes;
        int          failures;
        t_byte_q     s;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MAX_LENGTH;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        sb = new();
        phase_max = '{16'd1000, 16'd12, 16'd65535, 16'd40, 16'd0};
        phase_nul = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
        phase_max[4] = 16'($urandom_range(0, 30));
        phase_nul[4] = 1'($urandom_range(0, 1));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings under the reset settings
        send_string('{8'h41});
        send_string('{8'h00});
        send_string('{8'hC3, 8'hA9});
        send_string('{8'hF0, 8'h9F, 8'h98, 8'h80});
        send_string('{8'hC0, 8'h80});
        send_string('{8'hE0, 8'h80, 8'hAF});
        send_string('{8'hED, 8'hA0, 8'h80});
        send_string('{8'hF4, 8'h90, 8'h80, 8'h80});
        send_string('{8'hF5});
        send_string('{8'hFF});
        send_string('{8'h80});
        // missing continuation, then a good sequence that cannot clear the fault
        send_string('{8'hC3, 8'h41, 8'hC3, 8'hA9});
        // cut off by the end of the string
        send_string('{8'hE2, 8'h82});
        wait_idle();

        // zero byte as plain ascii, length right at the limit and one past it
        set_limits(16'd64, 1'b0);
        send_string('{8'h00});
        send_long_string(64, 1'b0);
        send_long_string(65, 1'b1);
        no_gaps = 1'b0;
        wait_idle();

        // zero limit: nul wins over too long
        set_limits(16'd0, 1'b1);
        send_string('{8'h41});
        send_string('{8'h00, 8'h41});
        wait_idle();

        // random phases under different settings
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            set_limits(phase_max[p], phase_nul[p]);
            no_gaps = (p == 2);
            if (p == 1) hold_request = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                s = random_string();
                send_string(s);
                phase_bytes += s.size();
            end
        end
        no_gaps = 1'b0;
        wait_idle();
        repeat (10) @(posedge i_clk);

        failures = sb.mismatches + sb.outstanding();
        $display("sent %0d strings (%0d bytes) with %0d register writes, checked %0d verdicts",
                 strings_sent, bytes_sent, reg_writes, sb.checked);
        $display("verdicts: accepted %0d, nul %0d, too long %0d, bad utf-8 %0d; %0d mismatches",
                 sb.verdict_counts[VERDICT_ACCEPTED], sb.verdict_counts[VERDICT_NUL],
                 sb.verdict_counts[VERDICT_TOO_LONG], sb.verdict_counts[VERDICT_BAD_UTF8],
                 sb.mismatches);
        if (failures == 0) begin
            $display("utf8_input_validator test passed");
        end else begin
            $display("utf8_input_validator test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/utf8v_pkg.sv
rtl/utf8v_input_reg.sv
rtl/utf8v_decoder.sv
rtl/utf8v_core.sv
rtl/utf8_input_validator.sv
tb/testbench.sv
